[hw/rtl/fpp_pkg.sv]
// Shared types and constants for the Fitch parsimony engine.
`default_nettype none
package fpp_pkg;

	localparam int NODE_W  = 10;
	localparam int SET_W   = 31;
	localparam int SCORE_W = 10;
	localparam int KIND_W  = 3;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

	localparam logic [KIND_W-1:0] KIND_TIP  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DOWN = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SEED = 3'd2;
	localparam logic [KIND_W-1:0] KIND_UP   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] left_child;
		logic [NODE_W-1:0] right_child;
		logic [NODE_W-1:0] parent_node;
		logic [SET_W-1:0]  tip_set;
	} cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0]  out_node;
		logic [SET_W-1:0]   down_set;
		logic [SET_W-1:0]   up_set;
		logic [SCORE_W-1:0] change_count;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_RD1,
		ST_RD2,
		ST_EXEC
	} state_t;

endpackage
`default_nettype wire

[hw/rtl/fpp_ram.sv]
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module fpp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

[hw/rtl/fpp_slot.sv]
// Index reduction modulo the table size: a range of conditional subtract steps.
`default_nettype none
module fpp_slot #(
	parameter int MAX_NODES = 1024,
	parameter int K_HI      = 9,
	parameter int K_LO      = 5
) (
	input  wire logic [3:0][fpp_pkg::NODE_W-1:0] v_in,
	output logic      [3:0][fpp_pkg::NODE_W-1:0] v_out
);
	import fpp_pkg::*;

	localparam int W = $clog2(MAX_NODES) + NODE_W;

	always_comb begin
		logic [W-1:0] w;
		for (int i = 0; i < 4; i++) begin
			w = W'(v_in[i]);
			for (int k = K_HI; k >= K_LO; k--) begin
				if (w >= (W'(MAX_NODES) << k)) begin
					w = w - (W'(MAX_NODES) << k);
				end
			end
			v_out[i] = w[NODE_W-1:0];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/fitch_parsimony_passes.sv]
// Top level: Fitch parsimony engine over node tables held in two RAMs.
//
//   channel | signals            | beat taken when
//   --------+--------------------+-------------------------------
//   command | start, busy, cmd   | start high and busy low
//   result  | done, result       | done high (one cycle, no stall)
//
// Each beat runs index reduction (ST_RED), reads in ST_RD1 and ST_RD2 on
// the two-port node RAM (node, left and right child sets) and the uppass
// RAM (parent and node uppass sets), then compute-and-write (ST_EXEC).
// The result strobes in ST_IDLE, where the next command may enter.
// Reset clears the sequencer and the strobe; table entries are undefined
// until written. The receiver cannot stall; done is high for one cycle.
`default_nettype none
module fitch_parsimony_passes #(
	parameter int MAX_NODES  = 1024,
	parameter int STATE_BITS = 31
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire fpp_pkg::cmd_t    cmd,
	output logic                  done,
	output fpp_pkg::result_t      result
);
	import fpp_pkg::*;

	localparam int DEPTH  = (MAX_NODES < (2 ** NODE_W)) ? MAX_NODES : (2 ** NODE_W);
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int SB     = STATE_BITS;
	localparam int NODE_E = SB + SCORE_W;

	localparam int I_NODE = 0;
	localparam int I_LC   = 1;
	localparam int I_RC   = 2;
	localparam int I_PA   = 3;

	state_t state_q, state_d;

	logic [KIND_W-1:0]               kind_q;
	logic [NODE_W-1:0]               node_q;
	logic [SB-1:0]                   tip_q;
	logic [3:0][NODE_W-1:0]          idx_s1;
	logic [3:0][IDX_W-1:0]           idx_s2;
	logic [3:0][NODE_W-1:0]          red1_v;
	logic [3:0][NODE_W-1:0]          red2_v;

	logic [NODE_E-1:0] na_q, nb_q;
	logic [SB-1:0]     ua_q, ub_q;

	logic [IDX_W-1:0]  node_ra_a, node_ra_b;
	logic [NODE_E-1:0] node_rd_a, node_rd_b, node_wd;
	logic [SB-1:0]     up_rd_a, up_rd_b, up_wd;
	logic              node_we, up_we;

	logic [SB-1:0]      res_down, res_up;
	logic [SCORE_W-1:0] res_score;

	logic [SB-1:0]      na_down, nb_down, rc_down, g_and, g_sel, f_set;
	logic [SCORE_W-1:0] na_score, nb_score, sum_sat;
	logic [SCORE_W:0]   sum;

	logic              done_q;
	result_t           result_q;

	fpp_slot #(.MAX_NODES(MAX_NODES), .K_HI(9), .K_LO(5)) u_slot_hi (
		.v_in  ({cmd.parent_node, cmd.right_child, cmd.left_child, cmd.node}),
		.v_out (red1_v)
	);

	fpp_slot #(.MAX_NODES(MAX_NODES), .K_HI(4), .K_LO(0)) u_slot_lo (
		.v_in  (idx_s1),
		.v_out (red2_v)
	);

	fpp_ram #(.WIDTH(NODE_E), .DEPTH(DEPTH)) u_node_ram (
		.clk     (clk),
		.we      (node_we),
		.waddr   (idx_s2[I_NODE]),
		.wdata   (node_wd),
		.raddr_a (node_ra_a),
		.raddr_b (node_ra_b),
		.rdata_a (node_rd_a),
		.rdata_b (node_rd_b)
	);

	fpp_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_up_ram (
		.clk     (clk),
		.we      (up_we),
		.waddr   (idx_s2[I_NODE]),
		.wdata   (up_wd),
		.raddr_a (idx_s2[I_PA]),
		.raddr_b (idx_s2[I_NODE]),
		.rdata_a (up_rd_a),
		.rdata_b (up_rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_EXEC);
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = ST_RED;
				end
			end
			ST_RED:  state_d = ST_RD1;
			ST_RD1:  state_d = ST_RD2;
			ST_RD2:  state_d = ST_EXEC;
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_q <= cmd.kind;
			node_q <= cmd.node;
			tip_q  <= cmd.tip_set[SB-1:0];
			idx_s1 <= red1_v;
		end
		if (state_q == ST_RED) begin
			for (int i = 0; i < 4; i++) begin
				idx_s2[i] <= red2_v[i][IDX_W-1:0];
			end
		end
		if (state_q == ST_RD2) begin
			na_q <= node_rd_a;
			nb_q <= node_rd_b;
			ua_q <= up_rd_a;
			ub_q <= up_rd_b;
		end
		if (state_q == ST_EXEC) begin
			result_q.out_node     <= node_q;
			result_q.down_set     <= SET_W'(res_down);
			result_q.up_set       <= SET_W'(res_up);
			result_q.change_count <= res_score;
		end
	end

	always_comb begin
		if (state_q == ST_RD2) begin
			node_ra_a = idx_s2[I_RC];
		end else if (kind_q == KIND_DOWN) begin
			node_ra_a = idx_s2[I_LC];
		end else begin
			node_ra_a = idx_s2[I_NODE];
		end
		node_ra_b = (kind_q == KIND_DOWN) ? idx_s2[I_RC] : idx_s2[I_LC];
	end

	always_comb begin
		na_down  = na_q[SB-1:0];
		na_score = na_q[SB +: SCORE_W];
		nb_down  = nb_q[SB-1:0];
		nb_score = nb_q[SB +: SCORE_W];
		rc_down  = node_rd_a[SB-1:0];

		g_and   = na_down & nb_down;
		g_sel   = (g_and == '0) ? (na_down | nb_down) : g_and;
		sum     = {1'b0, na_score} + {1'b0, nb_score} + (SCORE_W + 1)'(g_and == '0);
		sum_sat = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];

		if ((na_down & ua_q) == ua_q) begin
			f_set = ua_q;
		end else if ((nb_down & rc_down) == '0) begin
			f_set = na_down | ua_q;
		end else begin
			f_set = ((nb_down | rc_down) & ua_q) | na_down;
		end

		unique case (kind_q)
			KIND_TIP: begin
				res_down  = tip_q;
				res_up    = tip_q;
				res_score = '0;
			end
			KIND_DOWN: begin
				res_down  = g_sel;
				res_up    = '0;
				res_score = sum_sat;
			end
			KIND_SEED: begin
				res_down  = na_down;
				res_up    = na_down;
				res_score = na_score;
			end
			KIND_UP: begin
				res_down  = na_down;
				res_up    = f_set;
				res_score = na_score;
			end
			default: begin
				res_down  = na_down;
				res_up    = ub_q;
				res_score = na_score;
			end
		endcase

		node_we = (state_q == ST_EXEC) && ((kind_q == KIND_TIP) || (kind_q == KIND_DOWN));
		up_we   = (state_q == ST_EXEC) && (kind_q <= KIND_UP);
		node_wd = {res_score, res_down};
		up_wd   = res_up;
	end

	assign done   = done_q;
	assign result = result_q;

	a_beat_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("command beat without result five cycles later");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held two cycles");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_paired_write: assert property (@(posedge clk) disable iff (!arst_n)
		node_we |-> up_we)
		else $error("node table written without uppass table");

endmodule
`default_nettype wire
